### design/ficsc_pkg.sv
// Shared types, codes and constants of the flow inter-arrival chi-square classifier.
// No dependencies; used by the top level and the serial divider.
`default_nettype none
package ficsc_pkg;

   localparam int FLOW_SLOTS = 256;
   localparam int MAX_BINS   = 7;
   localparam int SLOT_W     = $clog2(FLOW_SLOTS);
   localparam int BIN_AW     = $clog2(FLOW_SLOTS * MAX_BINS);
   localparam int BIN_IW     = $clog2(MAX_BINS + 1);

   localparam int KEY_MULT   = 59;
   localparam int MIN_HDR    = 5;
   localparam int PROTO_TCP  = 6;
   localparam int ZERO_BIN_X = 5;

   localparam int NUM_W  = 50;   // (diff^2) << 16
   localparam int DEN_W  = 16;
   localparam int DIFF_W = 17;
   localparam int SQ_W   = 34;
   localparam int SUM_W  = 53;

   localparam logic [31:0] THRESHOLD_RESET = 32'd1000000;
   localparam logic [15:0] PPT_RESET       = 16'd300;
   localparam logic [2:0]  BINS_RESET      = 3'd7;

   // status codes
   localparam logic [2:0] STATUS_NEW      = 3'd0;
   localparam logic [2:0] STATUS_COUNTED  = 3'd1;
   localparam logic [2:0] STATUS_PASSED   = 3'd2;
   localparam logic [2:0] STATUS_FAILED   = 3'd3;
   localparam logic [2:0] STATUS_TRUSTED  = 3'd4;
   localparam logic [2:0] STATUS_UNRECOG  = 3'd5;
   localparam logic [2:0] STATUS_CONFLICT = 3'd6;
   localparam logic [2:0] STATUS_DROPPED  = 3'd7;

   // slot states
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_COLLECT = 2'd1;
   localparam logic [1:0] SLOT_TRUSTED = 2'd2;
   localparam logic [1:0] SLOT_UNRECOG = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_EDGES_0_1 = 3'd0;
   localparam logic [2:0] CSR_EDGES_2_3 = 3'd1;
   localparam logic [2:0] CSR_EDGES_4_5 = 3'd2;
   localparam logic [2:0] CSR_EDGE_6    = 3'd3;
   localparam logic [2:0] CSR_BINS      = 3'd4;
   localparam logic [2:0] CSR_THRESHOLD = 3'd5;
   localparam logic [2:0] CSR_PPT       = 3'd6;

   typedef struct packed {
      logic [3:0]  ip_header_words;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [63:0] arrival_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] flow_key;
      logic [39:0] statistic;
      logic [31:0] trusted_packets;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  state;
      logic [31:0] key;
      logic [63:0] last_time;
      logic [15:0] count;
   } slot_entry_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numer;
      logic [DEN_W-1:0]  denom;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_KEY, ST_READ, ST_LOOK, ST_CLEAR, ST_SCAN, ST_BIN_RD, ST_BIN_WR,
      ST_UPD, ST_CHI_RD, ST_CHI_SQ, ST_CHI_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_VERDICT
   } fsm_type;

   function automatic logic [DIFF_W-1:0] ref_count(input logic [BIN_IW-1:0] idx);
      logic [DIFF_W-1:0] val;
      case (idx)
         3'd0:    val = 17'd23;
         3'd1:    val = 17'd96714;
         3'd2:    val = 17'd25852;
         3'd3:    val = 17'd100444;
         3'd4:    val = 17'd7564;
         3'd5:    val = 17'd5;
         3'd6:    val = 17'd19433;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### design/ficsc_divider.sv
// Restoring bit-serial divider for one chi-square term, one quotient bit per cycle.
// Depends on ficsc_pkg.
`default_nettype none
module ficsc_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ficsc_pkg::div_req_type      div_req,
   output logic                             div_done,
   output logic [ficsc_pkg::NUM_W-1:0]      div_quot
);

   localparam int CNT_W = $clog2(ficsc_pkg::NUM_W);

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [ficsc_pkg::NUM_W-1:0]    q_ff, q_in;
   logic [ficsc_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [ficsc_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [ficsc_pkg::DEN_W:0]      rem_shift;
   logic [ficsc_pkg::DEN_W:0]      rem_diff;
   logic                           ge;

   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      rem_shift = {rem_ff, q_ff[ficsc_pkg::NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      ge        = rem_shift >= {1'b0, den_ff};
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in   = div_req.numer;
         rem_in = '0;
         den_in = div_req.denom;
      end else if (run_ff) begin
         // quotient bits shift in behind the numerator bits
         rem_in = ge ? rem_diff[ficsc_pkg::DEN_W-1:0] : rem_shift[ficsc_pkg::DEN_W-1:0];
         q_in   = {q_ff[ficsc_pkg::NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ficsc_pkg::NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign div_quot = q_ff;

endmodule
`default_nettype wire

### design/flow_interarrival_chi_square_classifier_unit.sv
// Top level of the flow inter-arrival chi-square classifier: sequencer, slot and bin memories.
// Depends on ficsc_pkg and ficsc_divider.
//
// One packet is taken when start is high and busy low; busy stays high until its result
// is presented. Every result is shown for exactly one cycle with rsp_valid and cannot be
// held off. A dropped packet answers the cycle after acceptance and busy stays low. A
// conflict, trusted or unrecognized packet ends at the slot lookup, a new flow also clears
// all 7 bins (one bin cleared per cycle through the single bin memory port), a counted packet
// also runs the edge scan (one bin per cycle) and the slot update. A packet that completes
// the test adds one division per bin in use, by the 50-step serial divider shared by all terms.
`default_nettype none
module flow_interarrival_chi_square_classifier_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ficsc_pkg::req_type    req_data,
   output logic                       rsp_valid,
   output ficsc_pkg::rsp_type         rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [2:0]            csr_index,
   input  wire logic [63:0]           csr_data
);

   localparam int SW = ficsc_pkg::SLOT_W;
   localparam int IW = ficsc_pkg::BIN_IW;
   localparam int AW = ficsc_pkg::BIN_AW;

   // configuration
   logic [31:0] edge_ff [ficsc_pkg::MAX_BINS];
   logic [2:0]  bins_ff;
   logic [31:0] thr_ff;
   logic [15:0] ppt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ficsc_pkg::MAX_BINS; i++) edge_ff[i] <= '0;
         bins_ff <= ficsc_pkg::BINS_RESET;
         thr_ff  <= ficsc_pkg::THRESHOLD_RESET;
         ppt_ff  <= ficsc_pkg::PPT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ficsc_pkg::CSR_EDGES_0_1: begin
               edge_ff[0] <= csr_data[31:0];
               edge_ff[1] <= csr_data[63:32];
            end
            ficsc_pkg::CSR_EDGES_2_3: begin
               edge_ff[2] <= csr_data[31:0];
               edge_ff[3] <= csr_data[63:32];
            end
            ficsc_pkg::CSR_EDGES_4_5: begin
               edge_ff[4] <= csr_data[31:0];
               edge_ff[5] <= csr_data[63:32];
            end
            ficsc_pkg::CSR_EDGE_6:    edge_ff[6] <= csr_data[31:0];
            ficsc_pkg::CSR_BINS:      bins_ff <= csr_data[2:0];
            ficsc_pkg::CSR_THRESHOLD: thr_ff  <= csr_data[31:0];
            ficsc_pkg::CSR_PPT:       ppt_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [IW-1:0] used_bins;
   assign used_bins = (bins_ff > IW'(ficsc_pkg::MAX_BINS)) ? IW'(ficsc_pkg::MAX_BINS)
                                                            : IW'(bins_ff);

   // sequencer registers
   ficsc_pkg::fsm_type                state_ff, state_in;
   ficsc_pkg::req_type                req_ff, req_in;
   logic [31:0]                       key_ff, key_in;
   logic [SW-1:0]                     slot_ff, slot_in;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic [63:0]                       gap_ff, gap_in;
   logic [15:0]                       cnt_ff, cnt_in;
   logic [ficsc_pkg::DEN_W-1:0]       x_ff, x_in;
   logic [ficsc_pkg::DIFF_W-1:0]      d_ff, d_in;
   logic [ficsc_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic [ficsc_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [31:0]                       trusted_ff, trusted_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ficsc_pkg::rsp_type                rsp_ff, rsp_in;

   // memories
   ficsc_pkg::slot_entry_type         slot_mem [ficsc_pkg::FLOW_SLOTS];
   ficsc_pkg::slot_entry_type         slot_rd_ff;
   ficsc_pkg::slot_entry_type         slot_wdata;
   logic                              slot_we;
   logic [ficsc_pkg::FLOW_SLOTS-1:0]  slot_valid_ff;
   logic                              valid_set;
   logic [15:0]                       bin_mem [ficsc_pkg::FLOW_SLOTS * ficsc_pkg::MAX_BINS];
   logic [15:0]                       bin_rd_ff;
   logic [15:0]                       bin_wdata;
   logic                              bin_we;
   logic [AW-1:0]                     bin_addr;

   ficsc_pkg::div_req_type            div_req;
   logic                              div_done;
   logic [ficsc_pkg::NUM_W-1:0]       div_quot;

   ficsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign bin_addr = AW'(AW'(slot_ff) * AW'(ficsc_pkg::MAX_BINS)) + AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_ff] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_addr] <= bin_wdata;
      bin_rd_ff <= bin_mem[bin_addr];
   end

   logic                         drop;
   logic                         eff_free;
   logic [15:0]                  x_val;
   logic [ficsc_pkg::DIFF_W-1:0] ref_val;
   logic [ficsc_pkg::SUM_W-1:0]  thr_q16;
   logic                         pass;

   assign drop    = (req_data.ip_header_words < 4'(ficsc_pkg::MIN_HDR))
                 || (req_data.protocol != 8'(ficsc_pkg::PROTO_TCP));
   assign thr_q16 = ficsc_pkg::SUM_W'({thr_ff, 16'd0});
   assign pass    = sum_ff <= thr_q16;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      gap_in       = gap_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      trusted_in   = trusted_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      slot_we      = 1'b0;
      slot_wdata   = '{ficsc_pkg::SLOT_COLLECT, key_ff, req_ff.arrival_us, cnt_ff};
      valid_set    = 1'b0;
      bin_we       = 1'b0;
      bin_wdata    = '0;
      div_req      = '{1'b0, {sq_ff, 16'd0}, x_ff};
      eff_free     = !slot_valid_ff[slot_ff] || (slot_rd_ff.state == ficsc_pkg::SLOT_FREE);
      x_val        = (bin_rd_ff == 16'd0) ? 16'(ficsc_pkg::ZERO_BIN_X) : bin_rd_ff;
      ref_val      = ficsc_pkg::ref_count(idx_ff);

      case (state_ff)
         ficsc_pkg::ST_IDLE: begin
            if (start) begin
               if (drop) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{ficsc_pkg::STATUS_DROPPED, 32'd0, 40'd0, trusted_ff};
               end else begin
                  req_in   = req_data;
                  state_in = ficsc_pkg::ST_KEY;
               end
            end
         end
         ficsc_pkg::ST_KEY: begin
            if (req_ff.src_port < req_ff.dst_port)
               key_in = (req_ff.src_ip * 32'(ficsc_pkg::KEY_MULT)) ^ req_ff.dst_ip
                      ^ {req_ff.src_port, 16'd0} ^ {16'd0, req_ff.dst_port};
            else
               key_in = (req_ff.dst_ip * 32'(ficsc_pkg::KEY_MULT)) ^ req_ff.src_ip
                      ^ {req_ff.dst_port, 16'd0} ^ {16'd0, req_ff.src_port};
            slot_in  = SW'(key_in % ficsc_pkg::FLOW_SLOTS);
            state_in = ficsc_pkg::ST_READ;
         end
         ficsc_pkg::ST_READ: state_in = ficsc_pkg::ST_LOOK;
         ficsc_pkg::ST_LOOK: begin
            if (eff_free) begin
               slot_we    = 1'b1;
               slot_wdata = '{ficsc_pkg::SLOT_COLLECT, key_ff, req_ff.arrival_us, 16'd1};
               valid_set  = 1'b1;
               idx_in     = '0;
               state_in   = ficsc_pkg::ST_CLEAR;
            end else if (slot_rd_ff.key != key_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ficsc_pkg::STATUS_CONFLICT, key_ff, 40'd0, trusted_ff};
               state_in = ficsc_pkg::ST_IDLE;
            end else if (slot_rd_ff.state == ficsc_pkg::SLOT_TRUSTED) begin
               trusted_in   = trusted_ff + 32'd1;
               rsp_valid_in = 1'b1;
               rsp_in = '{ficsc_pkg::STATUS_TRUSTED, key_ff, 40'd0, trusted_in};
               state_in = ficsc_pkg::ST_IDLE;
            end else if (slot_rd_ff.state == ficsc_pkg::SLOT_UNRECOG) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ficsc_pkg::STATUS_UNRECOG, key_ff, 40'd0, trusted_ff};
               state_in = ficsc_pkg::ST_IDLE;
            end else begin
               // time going backwards counts as a zero gap
               gap_in   = (req_ff.arrival_us >= slot_rd_ff.last_time)
                        ? req_ff.arrival_us - slot_rd_ff.last_time : 64'd0;
               cnt_in   = slot_rd_ff.count + 16'd1;
               idx_in   = '0;
               state_in = ficsc_pkg::ST_SCAN;
            end
         end
         ficsc_pkg::ST_CLEAR: begin
            bin_we = 1'b1;
            if (idx_ff == IW'(ficsc_pkg::MAX_BINS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ficsc_pkg::STATUS_NEW, key_ff, 40'd0, trusted_ff};
               state_in = ficsc_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ficsc_pkg::ST_SCAN: begin
            if (idx_ff >= used_bins)
               state_in = ficsc_pkg::ST_UPD;
            else if (gap_ff < {32'd0, edge_ff[idx_ff]})
               state_in = ficsc_pkg::ST_BIN_RD;
            else
               idx_in = idx_ff + 1'b1;
         end
         ficsc_pkg::ST_BIN_RD: state_in = ficsc_pkg::ST_BIN_WR;
         ficsc_pkg::ST_BIN_WR: begin
            bin_we    = 1'b1;
            bin_wdata = bin_rd_ff + 16'd1;
            state_in  = ficsc_pkg::ST_UPD;
         end
         ficsc_pkg::ST_UPD: begin
            slot_we = 1'b1;
            if (cnt_ff >= ppt_ff) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = ficsc_pkg::ST_CHI_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ficsc_pkg::STATUS_COUNTED, key_ff, 40'd0, trusted_ff};
               state_in = ficsc_pkg::ST_IDLE;
            end
         end
         ficsc_pkg::ST_CHI_RD: begin
            if (idx_ff >= used_bins) state_in = ficsc_pkg::ST_VERDICT;
            else                     state_in = ficsc_pkg::ST_CHI_SQ;
         end
         ficsc_pkg::ST_CHI_SQ: begin
            x_in = x_val;
            d_in = ({1'b0, x_val} > ref_val) ? {1'b0, x_val} - ref_val
                                             : ref_val - {1'b0, x_val};
            state_in = ficsc_pkg::ST_CHI_MUL;
         end
         ficsc_pkg::ST_CHI_MUL: begin
            sq_in    = ficsc_pkg::SQ_W'(d_ff * d_ff);
            state_in = ficsc_pkg::ST_DIV_GO;
         end
         ficsc_pkg::ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ficsc_pkg::ST_DIV_WAIT;
         end
         ficsc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               sum_in   = sum_ff + ficsc_pkg::SUM_W'(div_quot);
               idx_in   = idx_ff + 1'b1;
               state_in = ficsc_pkg::ST_CHI_RD;
            end
         end
         ficsc_pkg::ST_VERDICT: begin
            slot_we          = 1'b1;
            slot_wdata.state = pass ? ficsc_pkg::SLOT_TRUSTED : ficsc_pkg::SLOT_UNRECOG;
            rsp_valid_in     = 1'b1;
            rsp_in = '{pass ? ficsc_pkg::STATUS_PASSED : ficsc_pkg::STATUS_FAILED, key_ff,
                       40'(sum_ff[ficsc_pkg::SUM_W-1:16]), trusted_ff};
            state_in = ficsc_pkg::ST_IDLE;
         end
         default: state_in = ficsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ficsc_pkg::ST_IDLE;
         trusted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         trusted_ff   <= trusted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_set) slot_valid_ff[slot_ff] <= 1'b1;
      end
      req_ff  <= req_in;
      key_ff  <= key_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      gap_ff  <= gap_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ficsc_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_drop_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ficsc_pkg::STATUS_DROPPED) |-> rsp_data.flow_key == 32'd0)
      else $error("dropped packet reported a nonzero key");

   a_stat_only_on_test: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ficsc_pkg::STATUS_PASSED
                 && rsp_data.status != ficsc_pkg::STATUS_FAILED) |-> rsp_data.statistic == 40'd0)
      else $error("statistic reported outside a test result");

   a_trusted_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ficsc_pkg::ST_LOOK) |=> (trusted_ff == $past(trusted_ff)))
      else $error("trusted counter moved outside the slot lookup");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ficsc_pkg::ST_DIV_WAIT)
      else $error("divider finished while the sequencer was not waiting");

   a_result_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result presented while an item is still in work");

endmodule
`default_nettype wire
